// ===== hw/rtl/mexp_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mexp_pkg
// Shared types for the modular exponentiation controller and datapath.
// ----------------------------------------------------------------------------
package mexp_pkg;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_INV_DIV,
    ST_INV_UPD,
    ST_INV_FIX,
    ST_BIT,
    ST_MUL_ACC,
    ST_MUL_SQR,
    ST_DONE
  } state_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic load;       // capture operands
    logic red_start;  // start base mod m
    logic inv_init;   // set up extended Euclid
    logic div_start;  // start g / r
    logic inv_upd;    // one Euclid update
    logic inv_fix;    // finish inverse into base
    logic mul_start;  // start a modular multiply
    logic mul_sqr;    // 1: base*base, 0: acc*base
    logic shift_exp;  // drop low exponent bit
    logic set_err;    // flag no inverse
    logic set_out;    // copy result to output register
  } cmd_t;

  // Datapath status to controller.
  typedef struct packed {
    logic busy;       // reducer / divider / multiplier running
    logic neg;        // exponent negative
    logic small_mod;  // modulus below 2
    logic base_zero;  // reduced base is zero
    logic r_zero;     // Euclid remainder zero
    logic g_one;      // Euclid gcd is one
    logic mag_zero;   // remaining exponent zero
    logic mag_lsb;    // low exponent bit
  } status_t;

endpackage
`default_nettype wire

// ===== hw/rtl/modular_exponentiation_signed_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// modular_exponentiation_signed_top
// base_value ** exponent mod modulus with signed exponent.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel in_valid/in_ready carries base_value and exponent; one
//    transaction is taken only while the sequencer is idle.
//  - Output channel out_valid/out_ready carries power_result and no_inverse
//    from an output register, so a stalled receiver holds the result while
//    the block already accepts and works on the next transaction; only the
//    final write of that next result waits for the register to empty.
//  - modulus is written through modulus_we/modulus_wdata while idle.
//  - Sequence, set by the bit-serial multiplier and shared divider: accept,
//    base reduction (skipped, straight to output, when modulus is below 2),
//    then per exponent bit a decision, a multiply when the bit is set, then
//    a square, then a final decision and the output write. A negative
//    exponent adds a Euclid pass of one divide and update per quotient
//    plus a fix step. A new transaction is taken only once the previous
//    one has finished and the sequencer is idle again.
//  - Reset (synchronous rst) restores modulus to 2^31-1, empties the output
//    register and returns the sequencer to idle.
// ----------------------------------------------------------------------------
module modular_exponentiation_signed_top #(
  parameter int VALUE_WIDTH = 31
) (
  input  wire  logic                   clk,
  input  wire  logic                   rst,
  input  wire  logic                   modulus_we,
  input  wire  logic [VALUE_WIDTH-1:0] modulus_wdata,
  input  wire  logic                   in_valid,
  output logic                         in_ready,
  input  wire  logic [VALUE_WIDTH-1:0] base_value,
  input  wire  logic signed [31:0]     exponent,
  output logic                         out_valid,
  input  wire  logic                   out_ready,
  output logic [VALUE_WIDTH-1:0]       power_result,
  output logic                         no_inverse
);

  logic [VALUE_WIDTH-1:0] modulus;
  mexp_pkg::cmd_t    cmd;
  mexp_pkg::status_t status;

  // configuration register, reset to the largest 31-bit prime
  always_ff @(posedge clk) begin
    if (rst) begin
      modulus <= VALUE_WIDTH'(64'd2147483647);
    end else if (modulus_we) begin
      modulus <= modulus_wdata;
    end
  end

  mexp_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_ready, .out_valid, .out_ready,
    .status, .cmd
  );

  mexp_datapath #(.W(VALUE_WIDTH)) u_dp (
    .clk, .rst, .modulus, .base_value, .exponent(exponent), .cmd, .status,
    .res_value(power_result), .res_err(no_inverse)
  );

`ifndef NO_ASSERTIONS
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && no_inverse |-> power_result == '0) else $error("error with value");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");
  a_rng: assert property (@(posedge clk) disable iff (rst)
    out_valid && !no_inverse && modulus > 1 |-> power_result < modulus)
    else $error("result not reduced");
`endif

endmodule
`default_nettype wire

// ===== hw/rtl/mexp_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mexp_datapath
// Operand registers, a bit-serial modular multiplier, a restoring divider
// shared by the base reduction and the Euclid quotients, and the Euclid
// coefficient registers.
// ----------------------------------------------------------------------------
module mexp_datapath #(
  parameter int W = 31
) (
  input  wire  logic           clk,
  input  wire  logic           rst,
  input  wire  logic [W-1:0]   modulus,
  input  wire  logic [W-1:0]   base_value,
  input  wire  logic [31:0]    exponent,
  input  wire  mexp_pkg::cmd_t cmd,
  output mexp_pkg::status_t    status,
  output logic [W-1:0]         res_value,
  output logic                 res_err
);

  localparam int CW = $clog2(W + 1);

  logic [W-1:0] m, b, acc, g, r;
  logic [32:0]  mag;
  logic         neg, err;
  logic signed [W+1:0] cx, cy;

  // multiplier: acc_m = (ma * mb) mod m, MSB first over mb
  logic [W-1:0] ma, mb, macc;
  logic [CW-1:0] mcnt;
  logic          mbusy;
  logic [W:0]    dbl, dbl_r, add, add_r;

  // divider: quotient and remainder of dn / dd
  logic [W-1:0] dn, dd, dq, drem;
  logic [CW-1:0] dcnt;
  logic          dbusy;
  logic [W:0]    dsh;

  // track which divider job and which multiply are running
  logic neg_div, mul_sqr_q, red_done;

  always_comb begin
    dbl   = {macc, 1'b0};
    dbl_r = (dbl >= {1'b0, m}) ? dbl - {1'b0, m} : dbl;
    add   = dbl_r + {1'b0, ma};
    add_r = (add >= {1'b0, m}) ? add - {1'b0, m} : add;
    dsh   = {drem, dn[W-1]};
  end

  logic signed [2*W+3:0] prod;
  logic signed [W+1:0]   nc;
  always_comb begin
    prod = $signed({1'b0, dq}) * cy;
    nc   = cx - prod[W+1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mbusy <= 1'b0;
      dbusy <= 1'b0;
    end else begin
      if (cmd.mul_start) begin
        mbusy <= 1'b1;
        ma    <= cmd.mul_sqr ? b : acc;
        mb    <= b;
        macc  <= '0;
        mcnt  <= CW'(W);
      end else if (mbusy) begin
        macc <= mb[W-1] ? add_r[W-1:0] : dbl_r[W-1:0];
        mb   <= {mb[W-2:0], 1'b0};
        mcnt <= mcnt - 1'b1;
        if (mcnt == CW'(1)) begin
          mbusy <= 1'b0;
        end
      end
      if (cmd.red_start || cmd.div_start) begin
        dbusy <= 1'b1;
        dn    <= cmd.red_start ? b : g;
        dd    <= cmd.red_start ? m : r;
        drem  <= '0;
        dq    <= '0;
        dcnt  <= CW'(W);
      end else if (dbusy) begin
        if (dsh >= {1'b0, dd}) begin
          drem <= W'(dsh - {1'b0, dd});
          dq   <= {dq[W-2:0], 1'b1};
        end else begin
          drem <= dsh[W-1:0];
          dq   <= {dq[W-2:0], 1'b0};
        end
        dn   <= {dn[W-2:0], 1'b0};
        dcnt <= dcnt - 1'b1;
        if (dcnt == CW'(1)) begin
          dbusy <= 1'b0;
        end
      end
    end
  end

  logic [32:0] mag_in;
  always_comb begin
    mag_in = exponent[31] ? 33'(-{1'b1, exponent}) : {1'b0, exponent};
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      m   <= modulus;
      b   <= base_value;
      acc <= W'(1);
      mag <= mag_in;
      neg <= exponent[31];
      err <= 1'b0;
    end
    // reduction finished: remainder replaces the base
    if (red_done) begin
      b <= (dsh >= {1'b0, dd}) ? W'(dsh - {1'b0, dd}) : dsh[W-1:0];
    end
    if (cmd.inv_init) begin
      g  <= m;
      r  <= b;
      cx <= '0;
      cy <= (W+2)'(1);
    end
    if (cmd.inv_upd) begin
      g  <= r;
      r  <= drem;
      cx <= cy;
      cy <= nc;
    end
    if (cmd.inv_fix) begin
      b <= cx[W+1] ? W'(cx + $signed({2'b00, m})) : cx[W-1:0];
    end
    if (mbusy && mcnt == CW'(1)) begin
      if (mul_sqr_q) begin
        b <= mb[W-1] ? add_r[W-1:0] : dbl_r[W-1:0];
      end else begin
        acc <= mb[W-1] ? add_r[W-1:0] : dbl_r[W-1:0];
      end
    end
    if (cmd.shift_exp) begin
      mag <= {1'b0, mag[32:1]};
    end
    if (cmd.set_err) begin
      err <= 1'b1;
    end
    if (cmd.set_out) begin
      res_value <= (err || m < W'(2)) ? '0 : acc;
      res_err   <= err && !(m < W'(2));
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.red_start) neg_div <= 1'b0;
    if (cmd.div_start) neg_div <= 1'b1;
    if (cmd.mul_start) mul_sqr_q <= cmd.mul_sqr;
  end
  assign red_done = dbusy && dcnt == CW'(1) && !neg_div;

  always_comb begin
    status.busy      = mbusy || dbusy;
    status.neg       = neg;
    status.small_mod = m < W'(2);
    status.base_zero = b == '0;
    status.r_zero    = r == '0;
    status.g_one     = g == W'(1);
    status.mag_zero  = mag == '0;
    status.mag_lsb   = mag[0];
  end

`ifndef NO_ASSERTIONS
  a_excl: assert property (@(posedge clk) disable iff (rst)
    !(cmd.mul_start && mbusy)) else $error("multiply restarted while busy");
  a_div: assert property (@(posedge clk) disable iff (rst)
    !((cmd.div_start || cmd.red_start) && dbusy)) else $error("divide restarted");
  a_red: assert property (@(posedge clk) disable iff (rst)
    $past(red_done) |-> b < m || m == '0) else $error("reduction out of range");
`endif

endmodule
`default_nettype wire

// ===== hw/rtl/mexp_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mexp_ctrl
// Sequencer: reduce, optional Euclid inverse, square-and-multiply, output.
// ----------------------------------------------------------------------------
module mexp_ctrl (
  input  wire  logic              clk,
  input  wire  logic              rst,
  input  wire  logic              in_valid,
  output logic                    in_ready,
  output logic                    out_valid,
  input  wire  logic              out_ready,
  input  wire  mexp_pkg::status_t status,
  output mexp_pkg::cmd_t          cmd
);

  mexp_pkg::state_t state, state_next;
  logic started, started_next;  // first cycle of a wait state issued
  logic out_full;

  logic take;
  // the output register decouples the receiver, so only the sequencer gates input
  assign in_ready = (state == mexp_pkg::ST_IDLE);
  assign take     = in_valid && in_ready;
  assign out_valid = out_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= mexp_pkg::ST_IDLE;
      started  <= 1'b0;
      out_full <= 1'b0;
    end else begin
      state   <= state_next;
      started <= started_next;
      if (cmd.set_out) begin
        out_full <= 1'b1;
      end else if (out_ready) begin
        out_full <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next   = state;
    started_next = 1'b0;
    case (state)
      mexp_pkg::ST_IDLE: if (take) state_next = mexp_pkg::ST_REDUCE;
      mexp_pkg::ST_REDUCE: begin
        started_next = 1'b1;
        if (status.small_mod) state_next = mexp_pkg::ST_DONE;
        else if (started && !status.busy) begin
          started_next = 1'b0;
          if (!status.neg) state_next = mexp_pkg::ST_BIT;
          else if (status.base_zero) state_next = mexp_pkg::ST_DONE;
          else state_next = mexp_pkg::ST_INV_DIV;
        end
      end
      mexp_pkg::ST_INV_DIV: begin
        started_next = 1'b1;
        if (!started && status.r_zero) begin
          started_next = 1'b0;
          state_next = mexp_pkg::ST_INV_FIX;
        end else if (started && !status.busy) begin
          started_next = 1'b0;
          state_next = mexp_pkg::ST_INV_UPD;
        end
      end
      mexp_pkg::ST_INV_UPD: state_next = mexp_pkg::ST_INV_DIV;
      mexp_pkg::ST_INV_FIX: state_next = status.g_one ? mexp_pkg::ST_BIT : mexp_pkg::ST_DONE;
      mexp_pkg::ST_BIT: begin
        if (status.mag_zero) state_next = mexp_pkg::ST_DONE;
        else if (status.mag_lsb) state_next = mexp_pkg::ST_MUL_ACC;
        else state_next = mexp_pkg::ST_MUL_SQR;
      end
      mexp_pkg::ST_MUL_ACC: begin
        started_next = 1'b1;
        if (started && !status.busy) begin
          started_next = 1'b0;
          state_next = mexp_pkg::ST_MUL_SQR;
        end
      end
      mexp_pkg::ST_MUL_SQR: begin
        started_next = 1'b1;
        if (started && !status.busy) begin
          started_next = 1'b0;
          state_next = mexp_pkg::ST_BIT;
        end
      end
      mexp_pkg::ST_DONE: if (!out_full || out_ready) state_next = mexp_pkg::ST_IDLE;
      default: state_next = mexp_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    case (state)
      mexp_pkg::ST_IDLE: cmd.load = take;
      mexp_pkg::ST_REDUCE: if (!started && !status.small_mod) cmd.red_start = 1'b1;
      mexp_pkg::ST_INV_DIV: if (!started && !status.r_zero) cmd.div_start = 1'b1;
      mexp_pkg::ST_INV_UPD: cmd.inv_upd = 1'b1;
      mexp_pkg::ST_INV_FIX: begin
        if (status.g_one) cmd.inv_fix = 1'b1;
        else cmd.set_err = 1'b1;
      end
      mexp_pkg::ST_MUL_ACC: if (!started) cmd.mul_start = 1'b1;
      mexp_pkg::ST_MUL_SQR: begin
        if (!started) begin
          cmd.mul_start = 1'b1;
          cmd.mul_sqr   = 1'b1;
        end else if (!status.busy) begin
          cmd.shift_exp = 1'b1;
        end
      end
      mexp_pkg::ST_DONE: cmd.set_out = !out_full || out_ready;
      default: cmd = '0;
    endcase
    // Euclid setup alongside the end of reduction for a negative exponent
    if (state == mexp_pkg::ST_REDUCE && started && !status.busy && status.neg
        && !status.small_mod) begin
      cmd.inv_init = 1'b1;
    end
    if (state == mexp_pkg::ST_REDUCE && started && !status.busy && status.neg
        && status.base_zero && !status.small_mod) begin
      cmd.set_err = 1'b1;
    end
  end

`ifndef NO_ASSERTIONS
  a_load: assert property (@(posedge clk) disable iff (rst)
    take |=> state == mexp_pkg::ST_REDUCE) else $error("load did not start work");
  a_out: assert property (@(posedge clk) disable iff (rst)
    cmd.set_out |=> out_valid) else $error("result lost");
  a_one: assert property (@(posedge clk) disable iff (rst)
    !(cmd.mul_start && cmd.div_start)) else $error("two units started");
`endif

endmodule
`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Checks signed-exponent modular exponentiation against a behavioral model
// of square-and-multiply with an extended-Euclid inverse for negative powers.
// ----------------------------------------------------------------------------
module tb;

  localparam int W = 31;
  localparam longint LIMIT = 64'd6000000;

  typedef struct packed {
    logic [W-1:0] power;
    logic         noinv;
  } power_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic modulus_we = 1'b0;
  logic [W-1:0] modulus_wdata = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [W-1:0] base_value = '0;
  logic signed [31:0] exponent = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [W-1:0] power_result;
  logic no_inverse;

  // model copy of the modulus register
  logic [W-1:0] cur_modulus;
  power_t expected_powers[$];
  int errors = 0;
  longint cycles = 0;
  int stall_mode = 0;

  always #4 clk = ~clk;

  modular_exponentiation_signed_top #(.VALUE_WIDTH(W)) uut (
    .clk(clk), .rst(rst),
    .modulus_we(modulus_we), .modulus_wdata(modulus_wdata),
    .in_valid(in_valid), .in_ready(in_ready),
    .base_value(base_value), .exponent(exponent),
    .out_valid(out_valid), .out_ready(out_ready),
    .power_result(power_result), .no_inverse(no_inverse)
  );

  // (a*b) mod m; operands are below 2^31 so the product fits 64 bits
  function automatic logic [63:0] mulmod(logic [63:0] a, logic [63:0] b,
                                         logic [63:0] m);
    return (a * b) % m;
  endfunction

  function automatic power_t predict_power(logic [W-1:0] b_in,
                                           logic [31:0] e, logic [W-1:0] m_in);
    power_t res;
    logic [63:0] m, b, mag, acc, g, r, q, t;
    longint cx, cy, nc;
    res = '0;
    m = m_in;
    b = b_in;
    mag = e[31] ? {32'd0, (~e) + 32'd1} : {32'd0, e};
    if (e[31] && mag == 0) mag = 64'h8000_0000;
    if (m < 2) return res;
    b = b % m;
    if (e[31]) begin
      if (b == 0) begin
        res.noinv = 1'b1;
        return res;
      end
      g = m; r = b; cx = 0; cy = 1;
      while (r != 0) begin
        q = g / r;
        t = g % r;
        nc = cx - longint'(q) * cy;
        g = r; r = t; cx = cy; cy = nc;
      end
      if (g != 1) begin
        res.noinv = 1'b1;
        return res;
      end
      b = (cx < 0) ? 64'(cx + longint'(m)) : 64'(cx);
    end
    acc = 1;
    while (mag != 0) begin
      if (mag[0]) acc = mulmod(acc, b, m);
      b = mulmod(b, b, m);
      mag = mag >> 1;
    end
    res.power = acc[W-1:0];
    return res;
  endfunction

  // idle-only register write
  task automatic write_modulus(logic [W-1:0] value);
    @(negedge clk);
    modulus_we <= 1'b1;
    modulus_wdata <= value;
    @(negedge clk);
    modulus_we <= 1'b0;
    cur_modulus = value;
  endtask

  // one transaction; gaps come in bursts
  task automatic send_power(logic [W-1:0] b, logic signed [31:0] e);
    power_t pred;
    @(negedge clk);
    if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 12)) @(negedge clk);
    pred = predict_power(b, e, cur_modulus);
    expected_powers = {expected_powers, pred};
    in_valid <= 1'b1;
    base_value <= b;
    exponent <= e;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic drain();
    while (expected_powers.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
  endtask

  // receiver stall pattern; mode changes now and then
  always @(negedge clk) begin
    if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 2);
    case (stall_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom_range(0, 1) == 1);
      default: out_ready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  // result checker
  always @(posedge clk) begin
    power_t exp_p;
    cycles <= cycles + 1;
    if (!rst && out_valid && out_ready) begin
      if (expected_powers.size() == 0) begin
        $error("unexpected result transaction");
        errors = errors + 1;
      end else begin
        exp_p = expected_powers.pop_front();
        if (power_result !== exp_p.power) begin
          $error("power_result exp %0d got %0d", exp_p.power, power_result);
          errors = errors + 1;
        end
        if (no_inverse !== exp_p.noinv) begin
          $error("no_inverse exp %0d got %0d", exp_p.noinv, no_inverse);
          errors = errors + 1;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (cycles > LIMIT) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  // extremes of both fields, zero exponent, unreduced base, no inverse
  task automatic test_directed();
    write_modulus(31'h7FFF_FFFF);
    send_power(31'd0, 0);
    send_power(31'h7FFF_FFFF, 5);
    send_power(31'h7FFF_FFFE, 32'sh7FFF_FFFF);
    send_power(31'd3, -32'sh7FFF_FFFF);
    send_power(31'd12345, 32'sh8000_0000);
    send_power(31'd0, -1);
    send_power(31'd2, -1);
    drain();
    write_modulus(31'd2);
    send_power(31'd1, -1);
    send_power(31'h7FFF_FFFF, 32'sh8000_0000);
    send_power(31'd4, -3);
    send_power(31'd0, 0);
    drain();
    write_modulus(31'd12);
    send_power(31'd6, -2);
    send_power(31'd5, -2);
    send_power(31'd25, 3);
    send_power(31'h5555_5555, -32'sh5555_5555);
    drain();
  endtask

  // degenerate moduli 0 and 1 give 0 everywhere
  task automatic test_degenerate();
    write_modulus(31'd0);
    send_power(31'd7, -3);
    send_power(31'd0, 0);
    drain();
    write_modulus(31'd1);
    send_power(31'd9, 4);
    send_power(31'd0, -1);
    drain();
  endtask

  task automatic test_random(int n);
    logic [W-1:0] b;
    logic signed [31:0] e;
    for (int i = 0; i < n; i++) begin
      if (i % 40 == 0) begin
        drain();
        case ($urandom_range(0, 3))
          0: write_modulus(31'h7FFF_FFFF);
          1: write_modulus(W'($urandom_range(2, 100)));
          2: write_modulus(W'($urandom));
          default: write_modulus(31'd1000003);
        endcase
      end
      b = ($urandom_range(0, 4) == 0) ? W'($urandom_range(0, 20)) : W'($urandom);
      // mostly short exponents, some full width
      case ($urandom_range(0, 3))
        0: e = 32'($urandom);
        1: e = 32'sd0 - 32'($urandom_range(0, 1000));
        default: e = 32'($urandom_range(0, 1000));
      endcase
      send_power(b, e);
    end
    drain();
  endtask

  initial begin
    cur_modulus = 31'h7FFF_FFFF;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_degenerate();
    test_random(220);
    if (errors == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
